// File: rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and constants for the address resolution cache.
// ----------------------------------------------------------------------------
`default_nettype none
package arp_pkg;
   localparam int Entries = 128;
   localparam int IdxW = $clog2(Entries);
   localparam int CntW = $clog2(Entries + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   localparam logic [15:0] LIFETIME_RESET = 16'd1200;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] ip_address;
      logic [47:0] mac_address;
      logic        has_mac;
      logic [3:0]  interface_id;
      logic        is_static;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] found_mac;
      logic [3:0]  found_interface;
      logic        found_static;
      logic [7:0]  entry_count;
      logic [7:0]  removed_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic            load;     // latch request, clear scan state
      logic [IdxW-1:0] rd_addr;  // entry memory read address
      logic            scan;     // examine entry at scan_idx (read data valid)
      logic [IdxW-1:0] scan_idx; // index of the entry now in the read register
      logic            commit;   // apply the operation result
      logic            tick_inc; // advance seconds at load of a tick
   } cmd_type;
endpackage
`default_nettype wire

// File: rtl/arp_cache_table_top.sv
// ----------------------------------------------------------------------------
// ARP cache table top level
// Address resolution cache with add, lookup, delete and expiry tick.
// ----------------------------------------------------------------------------
// A request is accepted at the edge where start is high and busy is low; the
// controller then reads all 128 entries through the single read port of the
// entry memory, takes in the last read data, finishes the scan and commits,
// and the rsp_valid strobe rises after the commit. busy drops as the strobe
// rises, so the next request can be accepted at the edge that ends the
// strobe; no new request is taken while busy is high. The result is shown
// for one cycle only and cannot be stalled. Write entry_lifetime at address 0
// only while busy is low.
`default_nettype none
module arp_cache_table_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  arp_pkg::req_type       req_data,
   output logic                   rsp_valid,
   output arp_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [1:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   arp_pkg::cmd_type cmd;
   logic [15:0] lifetime_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= arp_pkg::LIFETIME_RESET;
      end else if (psel && penable && pwrite && paddr == 2'd0) begin
         lifetime_ff <= pwdata[15:0];
      end
   end
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {16'd0, lifetime_ff} : 32'd0;

   arp_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy), .cmd (cmd)
   );

   arp_dp u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .req_data (req_data),
      .lifetime (lifetime_ff), .rsp_valid (rsp_valid), .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

// File: rtl/arp_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences one request: load, scan every slot through the memory, commit.
// ----------------------------------------------------------------------------
`default_nettype none
module arp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output arp_pkg::cmd_type      cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_LAST = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [arp_pkg::IdxW-1:0] addr_ff, addr_in;
   logic rd_ok_ff, rd_ok_in;
   logic [arp_pkg::IdxW-1:0] rd_idx_ff;

   // advance through read address issue; read data is registered and valid in the cycle after
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      rd_ok_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               addr_in  = '0;
            end
         end
         S_SCAN: begin
            rd_ok_in = 1'b1;
            if (addr_ff == arp_pkg::IdxW'(arp_pkg::Entries - 1)) begin
               state_in = S_LAST;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_LAST: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         addr_ff  <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         rd_ok_ff <= rd_ok_in;
      end
      rd_idx_ff <= addr_ff;
   end

   assign busy = (state_ff != S_IDLE);
   always_comb begin
      cmd.load     = (state_ff == S_IDLE) && start;
      cmd.tick_inc = cmd.load;
      cmd.rd_addr  = addr_ff;
      cmd.scan     = rd_ok_ff;
      cmd.scan_idx = rd_idx_ff;
      cmd.commit   = (state_ff == S_DONE);
   end
endmodule
`default_nettype wire

// File: rtl/arp_dp.sv
// ----------------------------------------------------------------------------
// ARP cache datapath
// Entry memory, valid bits, scan comparators, counters and response register.
// ----------------------------------------------------------------------------
`default_nettype none
module arp_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  arp_pkg::cmd_type      cmd,
   input  arp_pkg::req_type      req_data,
   input  wire logic [15:0]      lifetime,
   output logic                  rsp_valid,
   output arp_pkg::rsp_type      rsp_data
);
   localparam int IW = arp_pkg::IdxW;
   localparam int CW = arp_pkg::CntW;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [3:0]  ifc;
      logic        stat;
      logic [31:0] expiry;
      logic [31:0] seq;
   } entry_type;

   entry_type mem [arp_pkg::Entries];
   entry_type rd_ff;
   logic [arp_pkg::Entries-1:0] valid_ff;

   arp_pkg::req_type req_ff;
   arp_pkg::rsp_type rsp_in;
   logic [31:0] sec_ff, seq_ctr_ff;
   logic [CW-1:0] total_ff;
   logic [CW-1:0] removed_ff, removed_in;
   logic free_hit_ff, free_hit_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic match_ff, match_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic [31:0] match_seq_ff, match_seq_in;
   logic [47:0] match_mac_ff, match_mac_in;
   logic [3:0]  match_ifc_ff, match_ifc_in;
   logic        match_stat_ff, match_stat_in;
   logic [arp_pkg::Entries-1:0] expire_ff, expire_in;
   logic ent_valid;
   logic do_add;

   // synchronous read port; write on add commit
   always_ff @(posedge clock) begin
      rd_ff <= mem[cmd.rd_addr];
      if (do_add) begin
         mem[free_idx_ff] <= '{ip: req_ff.ip_address,
            mac: req_ff.has_mac ? req_ff.mac_address : 48'd0,
            ifc: req_ff.interface_id, stat: req_ff.is_static,
            expiry: sec_ff + {16'd0, lifetime}, seq: seq_ctr_ff};
      end
   end

   assign ent_valid = valid_ff[cmd.scan_idx];
   assign do_add = cmd.commit && (req_ff.operation == arp_pkg::OP_ADD) && free_hit_ff;

   // examine one entry per cycle
   always_comb begin
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_seq_in  = match_seq_ff;
      match_mac_in  = match_mac_ff;
      match_ifc_in  = match_ifc_ff;
      match_stat_in = match_stat_ff;
      removed_in    = removed_ff;
      expire_in     = expire_ff;
      if (cmd.load) begin
         free_hit_in = 1'b0;
         match_in    = 1'b0;
         removed_in  = '0;
         expire_in   = '0;
      end else if (cmd.scan) begin
         if (!ent_valid && !free_hit_ff) begin
            free_hit_in = 1'b1;
            free_idx_in = cmd.scan_idx;
         end
         if (ent_valid && rd_ff.ip == req_ff.ip_address
             && (!match_ff || rd_ff.seq > match_seq_ff)) begin
            match_in      = 1'b1;
            match_idx_in  = cmd.scan_idx;
            match_seq_in  = rd_ff.seq;
            match_mac_in  = rd_ff.mac;
            match_ifc_in  = rd_ff.ifc;
            match_stat_in = rd_ff.stat;
         end
         if (ent_valid && !rd_ff.stat && rd_ff.expiry < sec_ff) begin
            expire_in[cmd.scan_idx] = 1'b1;
            removed_in = removed_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff   <= free_idx_in;
      match_idx_ff  <= match_idx_in;
      match_seq_ff  <= match_seq_in;
      match_mac_ff  <= match_mac_in;
      match_ifc_ff  <= match_ifc_in;
      match_stat_ff <= match_stat_in;
      removed_ff    <= removed_in;
      expire_ff     <= expire_in;
      free_hit_ff   <= free_hit_in;
      match_ff      <= match_in;
      if (cmd.load) req_ff <= req_data;
   end

   // commit: update table state, build response
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         sec_ff     <= '0;
         seq_ctr_ff <= '0;
         total_ff   <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= cmd.commit;
         if (cmd.tick_inc && req_data.operation == arp_pkg::OP_TICK) begin
            sec_ff <= sec_ff + 32'd1;
         end
         if (cmd.commit) begin
            case (req_ff.operation)
               arp_pkg::OP_ADD: begin
                  if (free_hit_ff) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                     seq_ctr_ff <= seq_ctr_ff + 32'd1;
                     total_ff <= total_ff + 1'b1;
                  end
               end
               arp_pkg::OP_DELETE: begin
                  if (match_ff) begin
                     valid_ff[match_idx_ff] <= 1'b0;
                     total_ff <= total_ff - 1'b1;
                  end
               end
               arp_pkg::OP_TICK: begin
                  valid_ff <= valid_ff & ~expire_ff;
                  total_ff <= total_ff - removed_ff;
               end
               default: ;
            endcase
         end
      end
   end

   // form the response from the scan result
   always_comb begin
      rsp_in = '0;
      case (req_ff.operation)
         arp_pkg::OP_ADD: begin
            rsp_in.status = free_hit_ff ? arp_pkg::ST_OK : arp_pkg::ST_FULL;
            rsp_in.entry_count = 8'(total_ff + (free_hit_ff ? 1'b1 : 1'b0));
         end
         arp_pkg::OP_LOOKUP: begin
            rsp_in.entry_count = 8'(total_ff);
            if (match_ff) begin
               rsp_in.found_mac       = match_mac_ff;
               rsp_in.found_interface = match_ifc_ff;
               rsp_in.found_static    = match_stat_ff;
            end else begin
               rsp_in.status = arp_pkg::ST_NOTFOUND;
            end
         end
         arp_pkg::OP_DELETE: begin
            rsp_in.status = match_ff ? arp_pkg::ST_OK : arp_pkg::ST_NOTFOUND;
            rsp_in.entry_count = 8'(total_ff - (match_ff ? 1'b1 : 1'b0));
            rsp_in.removed_count = match_ff ? 8'd1 : 8'd0;
         end
         default: begin
            rsp_in.entry_count   = 8'(total_ff - removed_ff);
            rsp_in.removed_count = 8'(removed_ff);
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data <= rsp_in;
      end
   end
endmodule
`default_nettype wire

// File: dv/arp_cache_table_top_tb.sv
// ----------------------------------------------------------------------------
// ARP cache table testbench
// Drives add, lookup, delete and tick requests into the cache, predicts each
// response with a behavioral copy of the table and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module arp_cache_table_top_tb;

   localparam int NumSlots = 128;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   arp_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   arp_pkg::rsp_type  rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [1:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   arp_cache_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // predicted table state
   logic        tbl_valid [NumSlots];
   logic [31:0] tbl_ip    [NumSlots];
   logic [47:0] tbl_mac   [NumSlots];
   logic [3:0]  tbl_ifc   [NumSlots];
   logic        tbl_static[NumSlots];
   logic [31:0] tbl_expiry[NumSlots];
   logic [31:0] tbl_seq   [NumSlots];
   logic [31:0] now_second;
   logic [31:0] insert_num;
   int          live_count;
   logic [15:0] lifetime;

   arp_pkg::rsp_type pending_rsp[$];
   int          errors = 0;
   int          rsp_seen = 0;
   int          sender_idle_pct = 0;
   int          ops_sent[4] = '{0, 0, 0, 0};

   // pool of addresses so lookups and deletes hit often
   logic [31:0] ip_pool[16];

   function automatic int newest_slot(logic [31:0] ip);
      int best;
      best = -1;
      for (int i = 0; i < NumSlots; i++)
         if (tbl_valid[i] && tbl_ip[i] == ip)
            if (best < 0 || tbl_seq[i] > tbl_seq[best]) best = i;
      return best;
   endfunction

   function automatic arp_pkg::rsp_type resolve(arp_pkg::req_type r);
      arp_pkg::rsp_type o;
      int      s;
      o = '0;
      o.status = arp_pkg::ST_OK;
      case (r.operation)
         arp_pkg::OP_ADD: begin
            s = -1;
            for (int i = 0; i < NumSlots; i++)
               if (s < 0 && !tbl_valid[i]) s = i;
            if (s < 0) begin
               o.status = arp_pkg::ST_FULL;
            end else begin
               tbl_valid[s]  = 1'b1;
               tbl_ip[s]     = r.ip_address;
               tbl_mac[s]    = r.has_mac ? r.mac_address : 48'd0;
               tbl_ifc[s]    = r.interface_id;
               tbl_static[s] = r.is_static;
               tbl_expiry[s] = now_second + {16'd0, lifetime};
               tbl_seq[s]    = insert_num;
               insert_num++;
               live_count++;
            end
         end
         arp_pkg::OP_LOOKUP: begin
            s = newest_slot(r.ip_address);
            if (s < 0) begin
               o.status = arp_pkg::ST_NOTFOUND;
            end else begin
               o.found_mac       = tbl_mac[s];
               o.found_interface = tbl_ifc[s];
               o.found_static    = tbl_static[s];
            end
         end
         arp_pkg::OP_DELETE: begin
            s = newest_slot(r.ip_address);
            if (s < 0) begin
               o.status = arp_pkg::ST_NOTFOUND;
            end else begin
               tbl_valid[s] = 1'b0;
               live_count--;
               o.removed_count = 8'd1;
            end
         end
         default: begin
            now_second++;
            for (int i = 0; i < NumSlots; i++)
               if (tbl_valid[i] && !tbl_static[i] && tbl_expiry[i] < now_second) begin
                  tbl_valid[i] = 1'b0;
                  live_count--;
                  o.removed_count++;
               end
         end
      endcase
      o.entry_count = live_count[7:0];
      return o;
   endfunction

   // send one request, with an optional random gap in front
   task automatic send_request(arp_pkg::req_type r);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(resolve(r));
      ops_sent[r.operation]++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_op(logic [1:0] op, logic [31:0] ip, logic [47:0] mac,
                          logic hm, logic [3:0] ifc, logic st);
      arp_pkg::req_type r;
      r.operation = op; r.ip_address = ip; r.mac_address = mac;
      r.has_mac = hm; r.interface_id = ifc; r.is_static = st;
      send_request(r);
   endtask

   // hold until every response is in, plus a margin for the scan
   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_lifetime(logic [15:0] val);
      drain();
      psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {16'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      lifetime = val;
      @(posedge clock);
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      arp_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status); errors++;
            end
            if (rsp_data.found_mac !== e.found_mac) begin
               $error("found_mac exp %h got %h", e.found_mac, rsp_data.found_mac);
               errors++;
            end
            if (rsp_data.found_interface !== e.found_interface) begin
               $error("found_interface exp %0d got %0d", e.found_interface,
                      rsp_data.found_interface); errors++;
            end
            if (rsp_data.found_static !== e.found_static) begin
               $error("found_static exp %0d got %0d", e.found_static,
                      rsp_data.found_static); errors++;
            end
            if (rsp_data.entry_count !== e.entry_count) begin
               $error("entry_count exp %0d got %0d", e.entry_count,
                      rsp_data.entry_count); errors++;
            end
            if (rsp_data.removed_count !== e.removed_count) begin
               $error("removed_count exp %0d got %0d", e.removed_count,
                      rsp_data.removed_count); errors++;
            end
         end
      end
   end

   // directed: extremes, every operation, missing address, duplicates
   task automatic test_directed();
      send_op(arp_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '1, 1'b1, 4'hF, 1'b1);
      send_op(arp_pkg::OP_DELETE, 32'h0, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_ADD, 32'h0, '1, 1'b1, 4'hF, 1'b0);
      send_op(arp_pkg::OP_ADD, 32'hFFFF_FFFF, 48'hAAAA_5555_0F0F, 1'b0, 4'h0, 1'b1);
      send_op(arp_pkg::OP_ADD, 32'h0, 48'h1234_5678_9ABC, 1'b1, 4'h5, 1'b1);
      send_op(arp_pkg::OP_LOOKUP, 32'h0, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_DELETE, 32'h0, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_LOOKUP, 32'h0, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_TICK, '1, '1, 1'b1, 4'hF, 1'b1);
      send_op(arp_pkg::OP_DELETE, 32'h0, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_DELETE, 32'hFFFF_FFFF, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_DELETE, 32'h0, '0, 1'b0, 4'h0, 1'b0);
   endtask

   // lifetime zero expires on the next tick; fill the table to full
   task automatic test_expiry_and_full();
      write_lifetime(16'd0);
      for (int i = 0; i < 4; i++)
         send_op(arp_pkg::OP_ADD, 32'd100 + i, 48'd7, 1'b1, 4'(i), i[0]);
      send_op(arp_pkg::OP_TICK, '0, '0, 1'b0, 4'h0, 1'b0);
      send_op(arp_pkg::OP_TICK, '0, '0, 1'b0, 4'h0, 1'b0);
      write_lifetime(16'd3);
      for (int i = 0; i < NumSlots + 2; i++)
         send_op(arp_pkg::OP_ADD, ip_pool[i % 16], 48'({$urandom, $urandom}), 1'b1,
                 4'(i), 1'b0);
      for (int i = 0; i < 6; i++) send_op(arp_pkg::OP_TICK, '0, '0, 1'b0, 4'h0, 1'b0);
      write_lifetime(16'hFFFF);
   endtask

   task automatic test_random(int count);
      arp_pkg::req_type r;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         r.operation    = 2'($urandom_range(3));
         if ($urandom_range(99) < 40) r.operation = arp_pkg::OP_ADD;
         if (r.operation == arp_pkg::OP_TICK && $urandom_range(3) != 0)
            r.operation = arp_pkg::OP_LOOKUP;
         r.ip_address   = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(15)];
         r.mac_address  = 48'({$urandom, $urandom});
         r.has_mac      = 1'($urandom);
         r.interface_id = 4'($urandom);
         r.is_static    = ($urandom_range(3) == 0);
         send_request(r);
      end
   endtask

   initial begin
      for (int i = 0; i < NumSlots; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < 16; i++) ip_pool[i] = $urandom;
      now_second = '0; insert_num = '0; live_count = 0;
      lifetime = arp_pkg::LIFETIME_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_expiry_and_full();
      sender_idle_pct = 17;
      test_random(650);
      write_lifetime(16'd20);
      sender_idle_pct = 60;
      test_random(650);
      write_lifetime(16'd1);
      sender_idle_pct = 0;
      test_random(650);
      drain();
      $display("Covered %0d adds, %0d lookups, %0d deletes, %0d ticks; %0d responses.",
               ops_sent[arp_pkg::OP_ADD], ops_sent[arp_pkg::OP_LOOKUP],
               ops_sent[arp_pkg::OP_DELETE], ops_sent[arp_pkg::OP_TICK], rsp_seen);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
